// File: hdl/tmws_pkg.sv
// Shared types, constants and codes of the trimmed-mean weighted smoother.
`default_nettype none

package tmws_pkg;

    // Parameter defaults
    localparam int CHANNELS_DEF = 4;
    localparam int SAMPLES_DEF  = 20;

    // Field and state widths
    localparam int ACTION_W   = 2;
    localparam int CHAN_W     = 2;
    localparam int SAMPLE_W   = 8;
    localparam int SUM_W      = 13;
    localparam int CNT_W      = 5;
    localparam int HIST_DEPTH = 5;
    localparam int WSUM_W     = 12;

    // Command queue between front and back (depth is a power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Shared reciprocal multiplier: quotient = (x * recip) >> shift
    localparam int MUL_A_W = 13;
    localparam int MUL_B_W = 19;
    localparam int PROD_W  = 32;
    localparam int TRIM_SH = 18;
    localparam int TEN_SH  = 16;
    localparam logic [MUL_B_W-1:0] TEN_RECIP = 19'd6554;

    localparam logic [SAMPLE_W-1:0] MIN_INIT = 8'hFF;

    // Input action codes
    localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLOSE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_EMIT   = 2'd2;

    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_CLOSE,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] sample;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLOSE_DIFF,
        ST_CLOSE_MUL,
        ST_CLOSE_WR,
        ST_STATUS,
        ST_EMIT_SUM,
        ST_EMIT_MUL,
        ST_EMIT_OUT
    } t_state;

endpackage

`default_nettype wire

// File: hdl/tmws_front.sv
// Front end: accept and classify input transactions, queue commands for the back end.
`default_nettype none

module tmws_front #(
    parameter int CHANNELS = tmws_pkg::CHANNELS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [tmws_pkg::ACTION_W-1:0] i_action,
    input  wire logic [tmws_pkg::CHAN_W-1:0]   i_channel,
    input  wire logic [tmws_pkg::SAMPLE_W-1:0] i_sample,
    output tmws_pkg::t_head                    o_head,
    input  wire logic                          i_pop
);

    tmws_pkg::t_cmd in_cmd;
    logic           keep;
    logic           push;
    logic           pop;

    tmws_pkg::t_cmd                  r_q [tmws_pkg::QUEUE_DEPTH];
    logic [tmws_pkg::QCNT_W-1:0]     r_cnt;
    logic [tmws_pkg::QPTR_W-1:0]     r_wp;
    logic [tmws_pkg::QPTR_W-1:0]     r_rp;

    // Classify: drop unused action codes and samples for absent channels
    always_comb begin
        in_cmd.op      = tmws_pkg::OP_SAMPLE;
        in_cmd.channel = i_channel;
        in_cmd.sample  = i_sample;
        keep           = 1'b0;
        unique case (i_action)
            tmws_pkg::ACT_SAMPLE: begin
                in_cmd.op = tmws_pkg::OP_SAMPLE;
                keep      = (int'(i_channel) < CHANNELS);
            end
            tmws_pkg::ACT_CLOSE: begin
                in_cmd.op = tmws_pkg::OP_CLOSE;
                keep      = 1'b1;
            end
            tmws_pkg::ACT_EMIT: begin
                in_cmd.op = tmws_pkg::OP_EMIT;
                keep      = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_ready = (r_cnt != tmws_pkg::QCNT_W'(tmws_pkg::QUEUE_DEPTH));
    assign push    = i_valid && o_ready && keep;
    assign pop     = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= '0;
            r_rp  <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_cmd;
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_q[r_rp];

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count did not grow on a push");

endmodule

`default_nettype wire

// File: hdl/tmws_back.sv
// Back end: per-channel accumulators, history, shared reciprocal multiplier, result register.
`default_nettype none

module tmws_back #(
    parameter int CHANNELS = tmws_pkg::CHANNELS_DEF,
    parameter int SAMPLES  = tmws_pkg::SAMPLES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  tmws_pkg::t_head                    i_head,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_kind,
    output logic [tmws_pkg::CHAN_W-1:0]        o_out_channel,
    output logic [tmws_pkg::SAMPLE_W-1:0]      o_value,
    output logic                               o_frame_status,
    output logic                               o_last
);

    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TRIM_DIV = SAMPLES - 2;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);
    localparam logic [tmws_pkg::CNT_W-1:0] FULL_CNT = tmws_pkg::CNT_W'(SAMPLES);
    localparam logic [tmws_pkg::MUL_B_W-1:0] TRIM_RECIP =
        tmws_pkg::MUL_B_W'(((1 << tmws_pkg::TRIM_SH) + TRIM_DIV - 1) / TRIM_DIV);

    tmws_pkg::t_state r_state, n_state;
    logic [CH_W-1:0]  r_ch, n_ch;
    logic             r_incomp, n_incomp;

    logic [tmws_pkg::SUM_W-1:0]    r_sum [CHANNELS];
    logic [tmws_pkg::SAMPLE_W-1:0] r_max [CHANNELS];
    logic [tmws_pkg::SAMPLE_W-1:0] r_min [CHANNELS];
    logic [tmws_pkg::CNT_W-1:0]    r_cnt [CHANNELS];
    logic [tmws_pkg::SAMPLE_W-1:0] r_hist [CHANNELS][tmws_pkg::HIST_DEPTH];

    logic [tmws_pkg::SUM_W-1:0]  r_diff;
    logic                        r_full;
    logic [tmws_pkg::WSUM_W-1:0] r_wsum;
    logic [tmws_pkg::PROD_W-1:0] r_prod;

    logic                          r_ovalid;
    logic                          r_okind;
    logic [tmws_pkg::CHAN_W-1:0]   r_ochan;
    logic [tmws_pkg::SAMPLE_W-1:0] r_oval;
    logic                          r_ostat;
    logic                          r_olast;

    logic [CH_W-1:0]               acc_idx;
    logic [tmws_pkg::SUM_W-1:0]    cur_sum;
    logic [tmws_pkg::SAMPLE_W-1:0] cur_max;
    logic [tmws_pkg::SAMPLE_W-1:0] cur_min;
    logic [tmws_pkg::CNT_W-1:0]    cur_cnt;
    logic [tmws_pkg::SAMPLE_W-1:0] smp;
    logic [tmws_pkg::SUM_W-1:0]    upd_sum;
    logic [tmws_pkg::SAMPLE_W-1:0] upd_max;
    logic [tmws_pkg::SAMPLE_W-1:0] upd_min;
    logic [tmws_pkg::WSUM_W-1:0]   wsum;
    logic [tmws_pkg::MUL_A_W-1:0]  mul_a;
    logic [tmws_pkg::MUL_B_W-1:0]  mul_b;
    logic [tmws_pkg::PROD_W-1:0]   mul_p;
    logic [tmws_pkg::SAMPLE_W-1:0] trim_q;
    logic [tmws_pkg::SAMPLE_W-1:0] ten_q;

    logic                          out_free;
    logic                          out_load;
    logic                          acc_upd;
    logic                          acc_clr;
    logic                          hist_we;
    logic                          out_kind;
    logic [tmws_pkg::CHAN_W-1:0]   out_chan;
    logic [tmws_pkg::SAMPLE_W-1:0] out_val;
    logic                          out_stat;
    logic                          out_last;

    // Accumulator row: queue head channel while idle, walk counter otherwise
    assign acc_idx = (r_state == tmws_pkg::ST_IDLE) ? CH_W'(i_head.cmd.channel) : r_ch;
    assign cur_sum = r_sum[acc_idx];
    assign cur_max = r_max[acc_idx];
    assign cur_min = r_min[acc_idx];
    assign cur_cnt = r_cnt[acc_idx];

    assign smp     = i_head.cmd.sample;
    assign upd_sum = cur_sum + tmws_pkg::SUM_W'(smp);
    assign upd_max = (smp > cur_max) ? smp : cur_max;
    assign upd_min = (smp < cur_min) ? smp : cur_min;

    // 5*h0 + 2*h1 + h2 + h3 + h4
    assign wsum = (tmws_pkg::WSUM_W'(r_hist[r_ch][0]) << 2)
                + tmws_pkg::WSUM_W'(r_hist[r_ch][0])
                + (tmws_pkg::WSUM_W'(r_hist[r_ch][1]) << 1)
                + tmws_pkg::WSUM_W'(r_hist[r_ch][2])
                + tmws_pkg::WSUM_W'(r_hist[r_ch][3])
                + tmws_pkg::WSUM_W'(r_hist[r_ch][4]);

    // One multiplier serves both divisions by a constant
    assign mul_a = (r_state == tmws_pkg::ST_EMIT_MUL) ?
                   tmws_pkg::MUL_A_W'(r_wsum) : tmws_pkg::MUL_A_W'(r_diff);
    assign mul_b = (r_state == tmws_pkg::ST_EMIT_MUL) ? tmws_pkg::TEN_RECIP : TRIM_RECIP;
    assign mul_p = tmws_pkg::PROD_W'(mul_a) * tmws_pkg::PROD_W'(mul_b);

    assign trim_q = r_prod[tmws_pkg::TRIM_SH +: tmws_pkg::SAMPLE_W];
    assign ten_q  = r_prod[tmws_pkg::TEN_SH +: tmws_pkg::SAMPLE_W];

    assign out_free = !r_ovalid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tmws_pkg::ST_IDLE;
            r_ch     <= '0;
            r_incomp <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ch     <= n_ch;
            r_incomp <= n_incomp;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_ch     = r_ch;
        n_incomp = r_incomp;
        o_pop    = 1'b0;
        acc_upd  = 1'b0;
        acc_clr  = 1'b0;
        hist_we  = 1'b0;
        out_load = 1'b0;
        out_kind = 1'b0;
        out_chan = '0;
        out_val  = '0;
        out_stat = 1'b0;
        out_last = 1'b0;
        unique case (r_state)
            tmws_pkg::ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    unique case (i_head.cmd.op)
                        tmws_pkg::OP_SAMPLE: begin
                            acc_upd = (cur_cnt < FULL_CNT);
                        end
                        tmws_pkg::OP_CLOSE: begin
                            n_ch     = '0;
                            n_incomp = 1'b0;
                            n_state  = tmws_pkg::ST_CLOSE_DIFF;
                        end
                        tmws_pkg::OP_EMIT: begin
                            n_ch    = '0;
                            n_state = tmws_pkg::ST_EMIT_SUM;
                        end
                        default: begin
                            n_state = tmws_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            tmws_pkg::ST_CLOSE_DIFF: begin
                n_state = tmws_pkg::ST_CLOSE_MUL;
            end
            tmws_pkg::ST_CLOSE_MUL: begin
                n_state = tmws_pkg::ST_CLOSE_WR;
            end
            tmws_pkg::ST_CLOSE_WR: begin
                hist_we  = 1'b1;
                acc_clr  = 1'b1;
                n_incomp = r_incomp || !r_full;
                if (r_ch == LAST_CH) begin
                    n_state = tmws_pkg::ST_STATUS;
                end else begin
                    n_ch    = r_ch + 1'b1;
                    n_state = tmws_pkg::ST_CLOSE_DIFF;
                end
            end
            tmws_pkg::ST_STATUS: begin
                out_stat = r_incomp;
                out_last = 1'b1;
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = tmws_pkg::ST_IDLE;
                end
            end
            tmws_pkg::ST_EMIT_SUM: begin
                n_state = tmws_pkg::ST_EMIT_MUL;
            end
            tmws_pkg::ST_EMIT_MUL: begin
                n_state = tmws_pkg::ST_EMIT_OUT;
            end
            tmws_pkg::ST_EMIT_OUT: begin
                out_kind = 1'b1;
                out_chan = tmws_pkg::CHAN_W'(r_ch);
                out_val  = ten_q;
                out_last = (r_ch == LAST_CH);
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_ch == LAST_CH) begin
                        n_state = tmws_pkg::ST_IDLE;
                    end else begin
                        n_ch    = r_ch + 1'b1;
                        n_state = tmws_pkg::ST_EMIT_SUM;
                    end
                end
            end
        endcase
    end

    // Accumulators and history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_sum[c] <= '0;
                r_max[c] <= '0;
                r_min[c] <= tmws_pkg::MIN_INIT;
                r_cnt[c] <= '0;
                for (int k = 0; k < tmws_pkg::HIST_DEPTH; k++) begin
                    r_hist[c][k] <= '0;
                end
            end
        end else begin
            if (acc_upd) begin
                r_sum[acc_idx] <= upd_sum;
                r_max[acc_idx] <= upd_max;
                r_min[acc_idx] <= upd_min;
                r_cnt[acc_idx] <= cur_cnt + 1'b1;
            end
            if (acc_clr) begin
                r_sum[r_ch] <= '0;
                r_max[r_ch] <= '0;
                r_min[r_ch] <= tmws_pkg::MIN_INIT;
                r_cnt[r_ch] <= '0;
            end
            if (hist_we) begin
                for (int k = tmws_pkg::HIST_DEPTH - 1; k > 0; k--) begin
                    r_hist[r_ch][k] <= r_hist[r_ch][k-1];
                end
                // An incomplete channel repeats its newest value
                r_hist[r_ch][0] <= r_full ? trim_q : r_hist[r_ch][0];
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == tmws_pkg::ST_CLOSE_DIFF) begin
            r_diff <= cur_sum - tmws_pkg::SUM_W'(cur_max) - tmws_pkg::SUM_W'(cur_min);
            r_full <= (cur_cnt == FULL_CNT);
        end
        if (r_state == tmws_pkg::ST_EMIT_SUM) begin
            r_wsum <= wsum;
        end
        // Capture the product only in the multiply states; hold it while a result waits
        if ((r_state == tmws_pkg::ST_CLOSE_MUL) || (r_state == tmws_pkg::ST_EMIT_MUL)) begin
            r_prod <= mul_p;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_okind <= out_kind;
            r_ochan <= out_chan;
            r_oval  <= out_val;
            r_ostat <= out_stat;
            r_olast <= out_last;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_kind         = r_okind;
    assign o_out_channel  = r_ochan;
    assign o_value        = r_oval;
    assign o_frame_status = r_ostat;
    assign o_last         = r_olast;

    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ch <= LAST_CH)
        else $error("channel walk out of range");

    a_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_okind) |-> (r_olast && (r_oval == '0) && (r_ochan == '0)))
        else $error("status result malformed");

    for (genvar g = 0; g < CHANNELS; g++) begin : g_cnt_chk
        a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_cnt[g] <= FULL_CNT)
            else $error("sample count above frame size");
    end

endmodule

`default_nettype wire

// File: hdl/trimmed_mean_weighted_smoother.sv
// Top level of the trimmed-mean weighted smoother: front queue plus back-end sequencer.
// Order: a sample updates its channel when the back end pops it from the queue; a frame close
// walks every channel (difference, shared reciprocal multiply, history write), then presents
// its status result; an emit walks every channel (weighted sum, shared reciprocal multiply, load).
// Throughput: one sample per cycle while the back end is idle and not walking a close or emit.
// Reset (i_rst_n low, synchronous) clears the queue, accumulators, history and result register.
`default_nettype none

module trimmed_mean_weighted_smoother #(
    parameter int CHANNELS = tmws_pkg::CHANNELS_DEF,
    parameter int SAMPLES  = tmws_pkg::SAMPLES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input transactions
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [tmws_pkg::ACTION_W-1:0] i_action,
    input  wire logic [tmws_pkg::CHAN_W-1:0]   i_channel,
    input  wire logic [tmws_pkg::SAMPLE_W-1:0] i_sample,
    // result transactions
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_kind,
    output logic [tmws_pkg::CHAN_W-1:0]        o_out_channel,
    output logic [tmws_pkg::SAMPLE_W-1:0]      o_value,
    output logic                               o_frame_status,
    output logic                               o_last
);

    // Queue head toward the back end, and its pop strobe
    tmws_pkg::t_head head;
    logic            pop;

    // Front: classify actions, drop unused codes and absent channels, queue the rest
    tmws_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_action  (i_action),
        .i_channel (i_channel),
        .i_sample  (i_sample),
        .o_head    (head),
        .i_pop     (pop)
    );

    // Back: update accumulators, walk channels on close and emit, hold the result
    tmws_back #(
        .CHANNELS (CHANNELS),
        .SAMPLES  (SAMPLES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_out_channel  (o_out_channel),
        .o_value        (o_value),
        .o_frame_status (o_frame_status),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire
